[rtl/lphm_pkg.sv]
// shared constants, types and codes for the linear probe hash map unit
package lphm_pkg;

   localparam int MAX_SLOTS_LOG2 = 10;
   localparam int SLOT_COUNT     = 1 << MAX_SLOTS_LOG2;
   localparam int KEY_W          = 32;
   localparam int VAL_W          = 32;
   localparam int CAP_W          = 4;
   localparam int LG_W           = $clog2(MAX_SLOTS_LOG2 + 1);
   localparam int MIX_SHIFT      = 16;
   localparam logic [KEY_W-1:0] MIX_MULT  = 32'h045d_9f3b;
   localparam logic [CAP_W-1:0] CAP_RESET = 4'd10;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // request codes
   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_GET = 1'b1;

   typedef logic [MAX_SLOTS_LOG2-1:0] slot_idx_type;

   typedef struct packed {
      logic             req_type;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] write_value;
      slot_idx_type     start_slot;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic clearing;
      logic probing;
   } back_status_type;

endpackage

[rtl/linear_probe_hash_map_u32_unit.sv]
// top level of the linear probe hash map unit: front, job queue and back
//
// channel   direction  handshake                      payload
// req       in         start && !busy                 req_type, req_key, req_write_value
// rsp       out        rsp_valid, one cycle per beat  rsp_read_value, rsp_found, rsp_table_full
// csr       in         csr_write_enable               csr_write_data (capacity log2)
//
// the front takes no new request beat until it has run the two mix rounds on its one multiplier and queued the job
// the back takes a job while idle, then does one key ram read for each slot it probes
// key zero is answered by the back from its own register, with no probe
// after reset busy stays high while all 1024 slots of the key store are cleared
// the response side cannot stall; two queued jobs let the front run ahead of the back
module linear_probe_hash_map_u32_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [lphm_pkg::KEY_W-1:0]  req_key,
   input  logic [lphm_pkg::VAL_W-1:0]  req_write_value,
   output logic                        rsp_valid,
   output logic [lphm_pkg::VAL_W-1:0]  rsp_read_value,
   output logic                        rsp_found,
   output logic                        rsp_table_full,
   input  logic                        csr_write_enable,
   input  logic [lphm_pkg::CAP_W-1:0]  csr_write_data
);

   lphm_pkg::back_status_type back_status;
   lphm_pkg::fifo_status_type fifo_status;
   lphm_pkg::job_type         push_data;
   lphm_pkg::job_type         head;
   logic                      push;
   logic                      pop;

   lphm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .back_status     (back_status),
      .fifo_status     (fifo_status),
      .push            (push),
      .push_data       (push_data)
   );

   lphm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (fifo_status)
   );

   lphm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .fifo_status      (fifo_status),
      .pop              (pop),
      .back_status      (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_found        (rsp_found),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

[rtl/lphm_ram.sv]
// generic single write port ram with one registered read port
module lphm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lphm_fifo.sv]
// short job queue between the hashing front and the probing back
module lphm_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lphm_pkg::job_type         push_data,
   input  logic                      pop,
   output lphm_pkg::job_type         head,
   output lphm_pkg::fifo_status_type status
);

   lphm_pkg::job_type                  entry_ff [lphm_pkg::FIFO_DEPTH];
   logic [lphm_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lphm_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lphm_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == lphm_pkg::FIFO_CNT_W'(lphm_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/lphm_front.sv]
// request front: takes a beat, runs the key mix over a shared multiplier, queues the job
module lphm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [lphm_pkg::KEY_W-1:0]     req_key,
   input  logic [lphm_pkg::VAL_W-1:0]     req_write_value,
   input  lphm_pkg::back_status_type      back_status,
   input  lphm_pkg::fifo_status_type      fifo_status,
   output logic                           push,
   output lphm_pkg::job_type              push_data
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MIX1 = 4'b0010,
      F_MIX2 = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic                           req_type_ff, req_type_in;
   logic [lphm_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lphm_pkg::VAL_W-1:0]     value_ff, value_in;
   logic [lphm_pkg::KEY_W-1:0]     hash_ff, hash_in;
   logic [lphm_pkg::KEY_W-1:0]     mix_src;
   logic [lphm_pkg::KEY_W-1:0]     mix_x;
   logic [lphm_pkg::KEY_W-1:0]     mix_prod;

   assign busy = (state_ff != F_IDLE) || back_status.clearing;

   // one xor-shift and multiply per cycle; the last pass uses only the xor-shift
   assign mix_src  = (state_ff == F_MIX1) ? key_ff : hash_ff;
   assign mix_x    = (mix_src >> lphm_pkg::MIX_SHIFT) ^ mix_src;
   assign mix_prod = lphm_pkg::KEY_W'(mix_x * lphm_pkg::MIX_MULT);

   assign push                  = (state_ff == F_PUSH) && !fifo_status.full;
   assign push_data.req_type    = req_type_ff;
   assign push_data.key         = key_ff;
   assign push_data.write_value = value_ff;
   assign push_data.start_slot  = mix_x[lphm_pkg::MAX_SLOTS_LOG2-1:0];

   always_comb begin
      state_in    = state_ff;
      req_type_in = req_type_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      hash_in     = hash_ff;
      case (state_ff)
         F_IDLE: begin
            if (start && !busy) begin
               req_type_in = req_type;
               key_in      = req_key;
               value_in    = req_write_value;
               state_in    = F_MIX1;
            end
         end
         F_MIX1: begin
            hash_in  = mix_prod;
            state_in = F_MIX2;
         end
         F_MIX2: begin
            hash_in  = mix_prod;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!fifo_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      hash_ff     <= hash_in;
   end

endmodule

[rtl/lphm_back.sv]
// probing back: clears the key store after reset, then walks slots one per cycle for each job with a nonzero key
module lphm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lphm_pkg::CAP_W-1:0]     csr_write_data,
   input  lphm_pkg::job_type              head,
   input  lphm_pkg::fifo_status_type      fifo_status,
   output logic                           pop,
   output lphm_pkg::back_status_type      back_status,
   output logic                           rsp_valid,
   output logic [lphm_pkg::VAL_W-1:0]     rsp_read_value,
   output logic                           rsp_found,
   output logic                           rsp_table_full
);

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_PROBE = 3'b100
   } back_state_type;

   localparam lphm_pkg::slot_idx_type LAST_SLOT = '1;

   back_state_type                 state_ff, state_in;
   lphm_pkg::slot_idx_type         clr_addr_ff, clr_addr_in;
   lphm_pkg::job_type              job_ff, job_in;
   lphm_pkg::slot_idx_type         pos_ff, pos_in;
   lphm_pkg::slot_idx_type         probe_n_ff, probe_n_in;
   logic [lphm_pkg::VAL_W-1:0]     zero_val_ff, zero_val_in;
   logic [lphm_pkg::CAP_W-1:0]     cap_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lphm_pkg::VAL_W-1:0]     rsp_read_value_ff, rsp_read_value_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic                           rsp_table_full_ff, rsp_table_full_in;

   logic [lphm_pkg::LG_W-1:0]      active_lg;
   lphm_pkg::slot_idx_type         slot_mask;
   lphm_pkg::slot_idx_type         rd_addr;
   lphm_pkg::slot_idx_type         wr_addr;
   logic                           key_wr_en;
   logic [lphm_pkg::KEY_W-1:0]     key_wr_data;
   logic                           val_wr_en;
   logic [lphm_pkg::KEY_W-1:0]     slot_key;
   logic [lphm_pkg::VAL_W-1:0]     slot_val;
   logic                           key_match;
   logic                           slot_hit;

   // capacity above the largest table saturates
   always_comb begin
      if (int'(cap_ff) > lphm_pkg::MAX_SLOTS_LOG2) begin
         active_lg = lphm_pkg::LG_W'(lphm_pkg::MAX_SLOTS_LOG2);
      end else begin
         active_lg = lphm_pkg::LG_W'(cap_ff);
      end
   end

   assign slot_mask = ~(LAST_SLOT << active_lg);

   assign key_match = (slot_key == job_ff.key);
   assign slot_hit  = key_match || (slot_key == '0);

   assign back_status.clearing = (state_ff == B_CLEAR);
   assign back_status.probing  = (state_ff == B_PROBE);

   always_comb begin
      state_in          = state_ff;
      clr_addr_in       = clr_addr_ff;
      job_in            = job_ff;
      pos_in            = pos_ff;
      probe_n_in        = probe_n_ff;
      zero_val_in       = zero_val_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = '0;
      rsp_found_in      = 1'b0;
      rsp_table_full_in = 1'b0;
      pop               = 1'b0;
      rd_addr           = pos_ff;
      wr_addr           = pos_ff;
      key_wr_en         = 1'b0;
      key_wr_data       = job_ff.key;
      val_wr_en         = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            key_wr_en   = 1'b1;
            key_wr_data = '0;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            rd_addr = head.start_slot & slot_mask;
            if (!fifo_status.empty) begin
               pop = 1'b1;
               if (head.key == '0) begin
                  // key zero lives in its own register
                  rsp_valid_in = 1'b1;
                  if (head.req_type == lphm_pkg::REQ_SET) begin
                     zero_val_in = head.write_value;
                  end else begin
                     rsp_read_value_in = zero_val_ff;
                     rsp_found_in      = 1'b1;
                  end
               end else begin
                  job_in     = head;
                  pos_in     = head.start_slot & slot_mask;
                  probe_n_in = '0;
                  state_in   = B_PROBE;
               end
            end
         end
         B_PROBE: begin
            if (slot_hit) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
               if (job_ff.req_type == lphm_pkg::REQ_SET) begin
                  key_wr_en = 1'b1;
                  val_wr_en = 1'b1;
               end else if (key_match) begin
                  rsp_read_value_in = slot_val;
                  rsp_found_in      = 1'b1;
               end
            end else if (probe_n_ff == slot_mask) begin
               // walked every slot in use
               rsp_valid_in      = 1'b1;
               rsp_table_full_in = (job_ff.req_type == lphm_pkg::REQ_SET);
               state_in          = B_IDLE;
            end else begin
               pos_in     = (pos_ff + 1'b1) & slot_mask;
               probe_n_in = probe_n_ff + 1'b1;
               rd_addr    = pos_in;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         zero_val_ff  <= '0;
         cap_ff       <= lphm_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         zero_val_ff  <= zero_val_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff            <= job_in;
      pos_ff            <= pos_in;
      probe_n_ff        <= probe_n_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_table_full_ff <= rsp_table_full_in;
   end

   lphm_ram #(
      .WIDTH (lphm_pkg::KEY_W),
      .DEPTH (lphm_pkg::SLOT_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (rd_addr),
      .rd_data (slot_key)
   );

   lphm_ram #(
      .WIDTH (lphm_pkg::VAL_W),
      .DEPTH (lphm_pkg::SLOT_COUNT)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (wr_addr),
      .wr_data (job_ff.write_value),
      .rd_addr (rd_addr),
      .rd_data (slot_val)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_table_full_ff;

   a_no_rsp_while_clearing : assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !rsp_valid_ff)
      else $error("response beat during clearing pass");

   a_full_excludes_found : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_table_full_ff) |-> !rsp_found_ff)
      else $error("full and found together");

   a_probe_within_capacity : assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PROBE) |-> ((probe_n_ff & ~slot_mask) == '0))
      else $error("probe count beyond capacity");

   a_value_write_on_set : assert property (@(posedge clock) disable iff (reset)
      val_wr_en |-> (state_ff == B_PROBE && job_ff.req_type == lphm_pkg::REQ_SET && slot_hit))
      else $error("value write outside a set hit");

   a_pop_only_idle : assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == B_IDLE && !fifo_status.empty))
      else $error("job taken outside idle");

endmodule

[tb/testbench.sv]
// self-checking testbench for the linear probe hash map unit
module testbench;
   import lphm_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 64;
   localparam int POOL_MAX      = 24;
   localparam int POOL_KEEP     = 8;

   typedef struct packed {
      logic             req_type;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] write_value;
   } map_request_type;

   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic             found;
      logic             table_full;
   } map_reply_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             start            = 1'b0;
   logic             req_type         = REQ_SET;
   logic [KEY_W-1:0] req_key          = '0;
   logic [VAL_W-1:0] req_write_value  = '0;
   logic             csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data   = '0;
   logic             busy;
   logic             rsp_valid;
   logic [VAL_W-1:0] rsp_read_value;
   logic             rsp_found;
   logic             rsp_table_full;

   linear_probe_hash_map_u32_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_found        (rsp_found),
      .rsp_table_full   (rsp_table_full),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the map
   bit [KEY_W-1:0] shadow_keys [SLOT_COUNT];
   bit [VAL_W-1:0] shadow_values [SLOT_COUNT];
   bit [VAL_W-1:0] shadow_zero_value = '0;
   bit [CAP_W-1:0] shadow_cap_log2 = CAP_RESET;

   map_request_type queued_requests[$];
   map_reply_type   replies_due[$];
   logic [KEY_W-1:0] key_pool[$];

   logic req_taken  = 1'b0;
   bit   steady_run = 1'b0;
   int   gap_left   = 0;
   int   cycle_count = 0;
   int   failures   = 0;
   int   beats_taken = 0;
   int   get_hits   = 0;
   int   full_sets  = 0;
   bit [15:0] caps_seen = 16'h0400;

   function automatic int unsigned slots_log2(input bit [CAP_W-1:0] cap);
      return (cap > MAX_SLOTS_LOG2) ? MAX_SLOTS_LOG2 : cap;
   endfunction

   function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] x;
      x = k;
      x = ((x >> MIX_SHIFT) ^ x) * MIX_MULT;
      x = ((x >> MIX_SHIFT) ^ x) * MIX_MULT;
      x = (x >> MIX_SHIFT) ^ x;
      return x;
   endfunction

   // walk from the home slot to the key or the first empty slot
   function automatic bit find_slot(input logic [KEY_W-1:0] k, output int unsigned pos);
      int unsigned lg;
      int unsigned mask;
      int unsigned p;
      int unsigned n;
      lg   = slots_log2(shadow_cap_log2);
      mask = (1 << lg) - 1;
      p    = mix_key(k) & mask;
      pos  = 0;
      for (n = 0; n < (1 << lg); n++) begin
         if (shadow_keys[p] == '0 || shadow_keys[p] == k) begin
            pos = p;
            return 1'b1;
         end
         p = (p + 1) & mask;
      end
      return 1'b0;
   endfunction

   function automatic map_reply_type apply_map_request(input map_request_type r);
      map_reply_type rep;
      int unsigned   pos;
      bit            hit;
      rep = '0;
      if (r.req_type == REQ_SET) begin
         if (r.key == '0) begin
            shadow_zero_value = r.write_value;
         end else if (find_slot(r.key, pos)) begin
            shadow_keys[pos]   = r.key;
            shadow_values[pos] = r.write_value;
         end else begin
            rep.table_full = 1'b1;
         end
      end else begin
         if (r.key == '0) begin
            rep.read_value = shadow_zero_value;
            rep.found      = 1'b1;
         end else begin
            hit = find_slot(r.key, pos);
            if (hit && shadow_keys[pos] == r.key) begin
               rep.read_value = shadow_values[pos];
               rep.found      = 1'b1;
            end
         end
      end
      return rep;
   endfunction

   // request driver: one beat at a time, random gap after each unless the phase is a steady run
   always @(negedge clock) begin : drive_requests
      map_request_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (queued_requests.size() > 0) begin
            nxt = queued_requests.pop_front();
            req_type        <= nxt.req_type;
            req_key         <= nxt.key;
            req_write_value <= nxt.write_value;
            start           <= 1'b1;
            gap_left        <= steady_run ? 0 : $urandom_range(0, 4);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check result beats, then predict for a request beat taken here
   always @(posedge clock) begin : watch_ports
      map_reply_type   due;
      map_request_type beat;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               $error("unexpected result beat: read_value %h found %b table_full %b",
                      rsp_read_value, rsp_found, rsp_table_full);
               failures++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_read_value !== due.read_value) begin
                  $error("read_value: expected %h, got %h", due.read_value, rsp_read_value);
                  failures++;
               end
               if (rsp_found !== due.found) begin
                  $error("found: expected %b, got %b", due.found, rsp_found);
                  failures++;
               end
               if (rsp_table_full !== due.table_full) begin
                  $error("table_full: expected %b, got %b", due.table_full, rsp_table_full);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            beat = '{req_type, req_key, req_write_value};
            due  = apply_map_request(beat);
            replies_due.push_back(due);
            beats_taken++;
            if (due.found && beat.key != '0) get_hits++;
            if (due.table_full) full_sets++;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic push_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      queued_requests.push_back('{op, k, v});
   endtask

   task automatic wait_idle(input int settle);
      while (queued_requests.size() != 0 || start || busy !== 1'b0
             || replies_due.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      wait_idle(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      shadow_cap_log2  = v;
      caps_seen[v]     = 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = $urandom();
      return (k == '0) ? 32'h1 : k;
   endfunction

   // sets and gets, mostly over a small key pool so gets hit stored entries
   task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
      int unsigned      want;
      int               i;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      logic             op;
      write_capacity(cap);
      want = (1 << slots_log2(cap)) + 3;
      if (want > POOL_MAX) want = POOL_MAX;
      // older keys stay in the pool to probe entries placed under another mask
      while (key_pool.size() > POOL_KEEP) void'(key_pool.pop_front());
      while (key_pool.size() < want) key_pool.push_back(fresh_key());
      steady_run = ($urandom_range(0, 3) == 0);
      for (i = 0; i < count; i++) begin
         op = $urandom_range(0, 1) ? REQ_GET : REQ_SET;
         case ($urandom_range(0, 24))
            0, 1:    k = '0;
            2, 3, 4: k = $urandom();
            default: k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         endcase
         case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom();
         endcase
         push_request(op, k, v);
      end
   endtask

   initial begin : stimulus
      int caps[14] = '{15, 2, 3, 10, 4, 12, 1, 0, 5, 6, 7, 9, 2, 3};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, full size table from reset
      wait_idle(0);
      push_request(REQ_GET, 32'h0, 32'hdead_beef);
      push_request(REQ_SET, 32'h0, 32'hffff_ffff);
      push_request(REQ_GET, 32'h0, 32'h0);
      push_request(REQ_GET, 32'hffff_ffff, 32'h0);
      push_request(REQ_SET, 32'hffff_ffff, 32'h0);
      push_request(REQ_GET, 32'hffff_ffff, 32'hffff_ffff);
      push_request(REQ_SET, 32'h0000_0001, 32'ha5a5_a5a5);
      push_request(REQ_SET, 32'h0000_0001, 32'h5a5a_5a5a);
      push_request(REQ_GET, 32'h0000_0001, 32'h0);
      push_request(REQ_SET, 32'h0, 32'h0);

      // two slots: fill, overflow, then update a key already held
      write_capacity(4'd1);
      push_request(REQ_SET, 32'h1234_5678, 32'h1111_1111);
      push_request(REQ_SET, 32'h8000_0000, 32'h2222_2222);
      push_request(REQ_SET, 32'h0bad_f00d, 32'h3333_3333);
      push_request(REQ_GET, 32'h0bad_f00d, 32'h0);
      push_request(REQ_SET, 32'h1234_5678, 32'h4444_4444);
      push_request(REQ_GET, 32'h1234_5678, 32'h0);
      push_request(REQ_GET, 32'h8000_0000, 32'h0);
      push_request(REQ_SET, 32'h0, 32'h7777_7777);
      push_request(REQ_GET, 32'h0, 32'h0);

      // single slot
      write_capacity(4'd0);
      push_request(REQ_GET, 32'h8000_0000, 32'h0);
      push_request(REQ_SET, 32'hcafe_0001, 32'h5555_5555);
      push_request(REQ_GET, 32'hcafe_0001, 32'h0);

      foreach (caps[c]) run_random_phase(CAP_W'(caps[c]), 43);

      wait_idle(TAIL_CYCLES);
      $display("%0d request beats over %0d capacity settings in %0d cycles",
               beats_taken, $countones(caps_seen), cycle_count);
      $display("%0d gets hit a stored key, %0d sets met a full table", get_hits, full_sets);
      if (failures == 0 && replies_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/lphm_fifo.sv
rtl/lphm_front.sv
rtl/lphm_back.sv
rtl/linear_probe_hash_map_u32_unit.sv
tb/testbench.sv
